### rtl/brake_pressure_supervisor_unit_assert.svh
// assertion macros used by the brake pressure supervisor control module
`ifndef BRAKE_PRESSURE_SUPERVISOR_UNIT_ASSERT_SVH
`define BRAKE_PRESSURE_SUPERVISOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define BPS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BPS_ASSERT_SAME(label, ante, cons)
`define BPS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/bps_pkg.sv
// types and constants of the brake pressure supervisor
package bps_pkg;

    localparam int FRAC_BITS = 8;

    // pressure levels on the clamped pedal and the pressure path
    localparam logic [14:0] FULL_PRESS = 15'(100 << FRAC_BITS);
    localparam logic [14:0] HALF_PRESS = 15'(50 << FRAC_BITS);
    localparam logic [14:0] ABS_PEDAL  = 15'(80 << FRAC_BITS);

    // speed levels
    localparam logic [15:0] ABS_SPEED   = 16'(100 << FRAC_BITS);
    localparam logic [15:0] EMERG_SPEED = 16'(60 << FRAC_BITS);

    // levels on the raw signed pedal
    localparam logic signed [16:0] RAW_FULL  = 17'(100 << FRAC_BITS);
    localparam logic signed [16:0] RAW_STUCK = 17'(50 << FRAC_BITS);
    localparam logic signed [16:0] RAW_EMERG = 17'(90 << FRAC_BITS);
    localparam logic signed [16:0] RAW_HOLD  = 17'(80 << FRAC_BITS);
    localparam logic signed [16:0] RAW_LOW   = 17'(5 << FRAC_BITS);

    // hard deceleration: diff * 50 > 9 << FRAC_BITS
    localparam logic signed [16:0] DECEL_DIFF = 17'((9 << FRAC_BITS) / 50);

    localparam logic [7:0] STUCK_TRIP = 8'd5;
    localparam logic [7:0] STUCK_MAX  = 8'hFF;
    localparam logic [1:0] RECOVER_N  = 2'd3;

    // rear = floor(p * 7 / 10) as p * RECIP_7_10 >> RECIP_SHIFT
    localparam int               RECIP_SHIFT = 19;
    localparam logic [18:0]      RECIP_7_10  = 19'(7 * 52429);
    localparam int               REAR_PROD_W = 15 + RECIP_SHIFT;

    typedef enum logic [2:0] {
        CFG_ABS_SCALE    = 3'd0,
        CFG_WEAR_LIMIT   = 3'd1,
        CFG_OVERHEAT_LIM = 3'd2,
        CFG_REGEN_GAIN   = 3'd3,
        CFG_HOLD_FRAMES  = 3'd4,
        CFG_HOLD_PRESS   = 3'd5,
        CFG_HOLD_RELEASE = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [8:0]  abs_scale;
        logic [15:0] wear_limit;
        logic [10:0] overheat_limit;
        logic [15:0] regen_gain;
        logic [15:0] hold_frames;
        logic [14:0] hold_pressure;
        logic [15:0] hold_release_speed;
    } t_cfg;

    typedef struct packed {
        logic load_in;
        logic step_mul;
        logic step_mix;
        logic step_rear;
        logic load_out;
    } t_cmd;

endpackage

### rtl/bps_ifs.sv
// handshake channels of the brake pressure supervisor
interface bps_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pedal_level;
    logic [15:0]        road_speed;
    logic signed [10:0] brake_temperature;
    logic [15:0]        wear_voltage;
    logic signed [15:0] drive_torque;

    modport source (output valid, output pedal_level, output road_speed,
                    output brake_temperature, output wear_voltage,
                    output drive_torque, input ready);
    modport sink (input valid, input pedal_level, input road_speed,
                  input brake_temperature, input wear_voltage,
                  input drive_torque, output ready);
endinterface

interface bps_out_if;
    logic        valid;
    logic        ready;
    logic [14:0] total_pressure;
    logic [14:0] front_pressure;
    logic [14:0] rear_pressure;
    logic        abs_on;
    logic [7:0]  status_bits;

    modport source (output valid, output total_pressure, output front_pressure,
                    output rear_pressure, output abs_on, output status_bits,
                    input ready);
    modport sink (input valid, input total_pressure, input front_pressure,
                  input rear_pressure, input abs_on, input status_bits,
                  output ready);
endinterface

interface bps_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/brake_pressure_supervisor_unit.sv
// top level of the brake pressure supervisor
// Takes one 10 ms brake frame per item and returns one pressure command item.
// An item passes from acceptance to its result register through these steps: capture,
// the ABS and regen multipliers, the pressure and latch logic, the rear split
// reciprocal multiply, and the result load. The next item is accepted in the
// cycle after the load, so no new item is taken before the last one is loaded;
// a result that waits for o_out.ready holds the following item at its load
// step. Configuration writes are taken in every cycle and should only be
// made while no item is in progress.
module brake_pressure_supervisor_unit import bps_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bps_in_if.sink   i_in,
    bps_out_if.source o_out,
    bps_cfg_if.sink  i_cfg
);

    t_cfg cfg;
    t_cmd cmd;

    bps_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_wr_ready (i_cfg.ready),
        .o_cfg      (cfg)
    );

    bps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    bps_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_cfg               (cfg),
        .i_pedal_level       (i_in.pedal_level),
        .i_road_speed        (i_in.road_speed),
        .i_brake_temperature (i_in.brake_temperature),
        .i_wear_voltage      (i_in.wear_voltage),
        .i_drive_torque      (i_in.drive_torque),
        .o_total_pressure    (o_out.total_pressure),
        .o_front_pressure    (o_out.front_pressure),
        .o_rear_pressure     (o_out.rear_pressure),
        .o_abs_on            (o_out.abs_on),
        .o_status_bits       (o_out.status_bits)
    );

endmodule

### rtl/bps_cfg_regs.sv
// configuration register bank
module bps_cfg_regs import bps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_valid,
    input  logic [2:0]  i_wr_index,
    input  logic [15:0] i_wr_data,
    output logic        o_wr_ready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    assign o_wr_ready = 1'b1;
    assign o_cfg      = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.abs_scale          <= 9'd128;
            r_cfg.wear_limit         <= 16'd2500;
            r_cfg.overheat_limit     <= 11'd600;
            r_cfg.regen_gain         <= 16'd256;
            r_cfg.hold_frames        <= 16'd200;
            r_cfg.hold_pressure      <= 15'd7680;
            r_cfg.hold_release_speed <= 16'd768;
        end else if (i_wr_valid) begin
            case (t_cfg_idx'(i_wr_index))
                CFG_ABS_SCALE:    r_cfg.abs_scale          <= i_wr_data[8:0];
                CFG_WEAR_LIMIT:   r_cfg.wear_limit         <= i_wr_data;
                CFG_OVERHEAT_LIM: r_cfg.overheat_limit     <= i_wr_data[10:0];
                CFG_REGEN_GAIN:   r_cfg.regen_gain         <= i_wr_data;
                CFG_HOLD_FRAMES:  r_cfg.hold_frames        <= i_wr_data;
                CFG_HOLD_PRESS:   r_cfg.hold_pressure      <= i_wr_data[14:0];
                CFG_HOLD_RELEASE: r_cfg.hold_release_speed <= i_wr_data;
                default: begin
                end
            endcase
        end
    end

endmodule

### rtl/bps_ctrl.sv
// frame sequencer and output handshake
module bps_ctrl import bps_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

`include "brake_pressure_supervisor_unit_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_MIX,
        S_REAR,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.load_in   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.step_mul  = (r_state == S_MUL);
        o_cmd.step_mix  = (r_state == S_MIX);
        o_cmd.step_rear = (r_state == S_REAR);
        o_cmd.load_out  = (r_state == S_OUT) && out_free;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_MUL;
            S_MUL:  n_state = S_MIX;
            S_MIX:  n_state = S_REAR;
            S_REAR: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `BPS_ASSERT_NEXT(a_accept_starts, o_cmd.load_in, r_state == S_MUL)
    `BPS_ASSERT_NEXT(a_load_sets_valid, o_cmd.load_out, r_out_valid)
    `BPS_ASSERT_SAME(a_no_overwrite, r_out_valid && !i_out_ready, !o_cmd.load_out)

endmodule

### rtl/bps_datapath.sv
// frame arithmetic, supervisor state and result register
module bps_datapath import bps_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  t_cfg               i_cfg,
    input  logic signed [15:0] i_pedal_level,
    input  logic [15:0]        i_road_speed,
    input  logic signed [10:0] i_brake_temperature,
    input  logic [15:0]        i_wear_voltage,
    input  logic signed [15:0] i_drive_torque,
    output logic [14:0]        o_total_pressure,
    output logic [14:0]        o_front_pressure,
    output logic [14:0]        o_rear_pressure,
    output logic               o_abs_on,
    output logic [7:0]         o_status_bits
);

    // captured item
    logic signed [15:0] r_pedal;
    logic [15:0]        r_speed;
    logic signed [10:0] r_temp;
    logic [15:0]        r_wear;
    logic signed [15:0] r_torque;

    // multiply stage
    logic [14:0] r_pedal_c;
    logic [23:0] r_abs_prod;
    logic [30:0] r_regen_prod;
    logic        r_regen_on;
    logic        r_abs_act;

    // mix stage
    logic [14:0] r_press;
    logic [7:0]  r_status;
    logic        r_hard;

    // rear stage
    logic [REAR_PROD_W-1:0] r_rear_prod;

    // supervisor state
    logic        r_oh_lat;
    logic [1:0]  r_oh_rec;
    logic [7:0]  r_stuck_cnt;
    logic        r_stuck_lat;
    logic [1:0]  r_stuck_rec;
    logic [15:0] r_prev_speed;
    logic [15:0] r_hold_timer;
    logic [2:0]  r_heartbeat;

    // result
    logic [14:0] r_total;
    logic [14:0] r_rear;
    logic        r_abs_on;
    logic [7:0]  r_status_out;

    logic [14:0] pedal_c;
    logic [15:0] p_abs;
    logic [14:0] p0;
    logic [14:0] p1;
    logic [14:0] p2;
    logic [14:0] p3;
    logic [14:0] n_press;
    logic [14:0] hold_p;
    logic        wear_flag;
    logic        n_oh_lat;
    logic [1:0]  n_oh_rec;
    logic [1:0]  oh_rec_inc;
    logic        stuck_cond;
    logic [7:0]  stuck_inc;
    logic [7:0]  n_stuck_cnt;
    logic        n_stuck_lat;
    logic [1:0]  n_stuck_rec;
    logic [1:0]  stuck_rec_inc;
    logic [15:0] hold_t0;
    logic [15:0] n_hold_timer;
    logic signed [16:0] speed_diff;

    always_comb begin
        if (r_pedal[15]) begin
            pedal_c = '0;
        end else if (r_pedal > RAW_FULL) begin
            pedal_c = FULL_PRESS;
        end else begin
            pedal_c = r_pedal[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_pedal  <= i_pedal_level;
            r_speed  <= i_road_speed;
            r_temp   <= i_brake_temperature;
            r_wear   <= i_wear_voltage;
            r_torque <= i_drive_torque;
        end
        if (i_cmd.step_mul) begin
            r_pedal_c    <= pedal_c;
            r_abs_prod   <= 24'(pedal_c) * 24'(i_cfg.abs_scale);
            r_regen_prod <= 31'(r_torque[14:0]) * 31'(i_cfg.regen_gain);
            r_regen_on   <= !r_torque[15] && (r_torque != '0);
            r_abs_act    <= (r_speed > ABS_SPEED) && (pedal_c > ABS_PEDAL);
        end
    end

    // pressure path
    always_comb begin
        p_abs = r_abs_prod[23:8];
        if (r_abs_act) begin
            p0 = (p_abs > {1'b0, FULL_PRESS}) ? FULL_PRESS : p_abs[14:0];
        end else begin
            p0 = r_pedal_c;
        end

        if (r_regen_on) begin
            p1 = ({17'd0, p0} > {1'b0, r_regen_prod}) ? (p0 - r_regen_prod[14:0]) : '0;
        end else begin
            p1 = p0;
        end

        if ((r_pedal > RAW_EMERG) && (r_speed > EMERG_SPEED)) begin
            p2 = FULL_PRESS;
        end else begin
            p2 = p1;
        end

        p3 = (n_oh_lat && (p2 > HALF_PRESS)) ? HALF_PRESS : p2;

        hold_p = (i_cfg.hold_pressure > FULL_PRESS) ? FULL_PRESS : i_cfg.hold_pressure;
        hold_t0 = ((r_speed == '0) && (r_pedal > RAW_HOLD)) ? i_cfg.hold_frames : r_hold_timer;
        n_press      = p3;
        n_hold_timer = hold_t0;
        if (hold_t0 != '0) begin
            if (r_pedal < RAW_LOW) begin
                n_press      = hold_p;
                n_hold_timer = hold_t0 - 16'd1;
            end
            if (r_speed > i_cfg.hold_release_speed) begin
                n_hold_timer = '0;
            end
        end
    end

    // overheat and plausibility latches
    always_comb begin
        wear_flag  = r_wear > i_cfg.wear_limit;
        oh_rec_inc = r_oh_rec + 2'd1;
        n_oh_lat   = r_oh_lat;
        n_oh_rec   = r_oh_rec;
        if (r_temp > $signed(i_cfg.overheat_limit)) begin
            n_oh_lat = 1'b1;
            n_oh_rec = '0;
        end else if (r_oh_lat) begin
            n_oh_rec = oh_rec_inc;
            if (oh_rec_inc >= RECOVER_N) begin
                n_oh_lat = 1'b0;
                n_oh_rec = '0;
            end
        end

        stuck_cond    = (r_speed >= r_prev_speed) && (r_pedal > RAW_STUCK);
        stuck_inc     = (r_stuck_cnt != STUCK_MAX) ? (r_stuck_cnt + 8'd1) : r_stuck_cnt;
        stuck_rec_inc = r_stuck_rec + 2'd1;
        n_stuck_cnt   = r_stuck_cnt;
        n_stuck_lat   = r_stuck_lat;
        n_stuck_rec   = r_stuck_rec;
        if (stuck_cond) begin
            n_stuck_cnt = stuck_inc;
            if (stuck_inc >= STUCK_TRIP) begin
                n_stuck_lat = 1'b1;
                n_stuck_rec = '0;
            end
        end else begin
            n_stuck_cnt = '0;
            if (r_stuck_lat) begin
                n_stuck_rec = stuck_rec_inc;
                if (stuck_rec_inc >= RECOVER_N) begin
                    n_stuck_lat = 1'b0;
                    n_stuck_rec = '0;
                end
            end
        end

        speed_diff = $signed({1'b0, r_prev_speed}) - $signed({1'b0, r_speed});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oh_lat     <= 1'b0;
            r_oh_rec     <= '0;
            r_stuck_cnt  <= '0;
            r_stuck_lat  <= 1'b0;
            r_stuck_rec  <= '0;
            r_prev_speed <= '0;
            r_hold_timer <= '0;
            r_heartbeat  <= '0;
        end else if (i_cmd.step_mix) begin
            r_oh_lat     <= n_oh_lat;
            r_oh_rec     <= n_oh_rec;
            r_stuck_cnt  <= n_stuck_cnt;
            r_stuck_lat  <= n_stuck_lat;
            r_stuck_rec  <= n_stuck_rec;
            r_prev_speed <= r_speed;
            r_hold_timer <= n_hold_timer;
            r_heartbeat  <= r_heartbeat + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step_mix) begin
            r_press  <= n_press;
            r_status <= {r_heartbeat, n_stuck_lat, wear_flag, 1'b0, n_oh_lat, r_abs_act};
            r_hard   <= speed_diff > DECEL_DIFF;
        end
        if (i_cmd.step_rear) begin
            r_rear_prod <= REAR_PROD_W'(r_press) * REAR_PROD_W'(RECIP_7_10);
        end
        if (i_cmd.load_out) begin
            r_total      <= r_press;
            r_rear       <= r_hard ? r_rear_prod[RECIP_SHIFT +: 15] : r_press;
            r_abs_on     <= r_abs_act;
            r_status_out <= r_status;
        end
    end

    assign o_total_pressure = r_total;
    assign o_front_pressure = r_total;
    assign o_rear_pressure  = r_rear;
    assign o_abs_on         = r_abs_on;
    assign o_status_bits    = r_status_out;

endmodule
